>>> sv/epd_pkg.sv
// ---------------------------------------------------------------------------
// EAP packet decoder package
// Role and status codes, register indexes and shared types.
// ---------------------------------------------------------------------------
package epd_pkg;

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LOW         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_HIGH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AKA_PRIME_TYPE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY_TYPE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_TYPE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBTYPE_HIGH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_TYPE_HIGH   = 3'd7;

    // byte roles
    localparam logic [3:0] ROLE_CODE       = 4'd0;
    localparam logic [3:0] ROLE_ID         = 4'd1;
    localparam logic [3:0] ROLE_LEN_HI     = 4'd2;
    localparam logic [3:0] ROLE_LEN_LO     = 4'd3;
    localparam logic [3:0] ROLE_TYPE       = 4'd4;
    localparam logic [3:0] ROLE_SUBTYPE    = 4'd5;
    localparam logic [3:0] ROLE_RESERVED   = 4'd6;
    localparam logic [3:0] ROLE_ATTR_TYPE  = 4'd7;
    localparam logic [3:0] ROLE_ATTR_LEN   = 4'd8;
    localparam logic [3:0] ROLE_ATTR_VALUE = 4'd9;
    localparam logic [3:0] ROLE_RAW        = 4'd10;
    localparam logic [3:0] ROLE_IGNORED    = 4'd11;

    // status codes
    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_DONE        = 4'd1;
    localparam logic [3:0] ST_BAD_CODE    = 4'd2;
    localparam logic [3:0] ST_BAD_TYPE    = 4'd3;
    localparam logic [3:0] ST_BAD_SUBTYPE = 4'd4;
    localparam logic [3:0] ST_BAD_ATYPE   = 4'd5;
    localparam logic [3:0] ST_BAD_ALEN    = 4'd6;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd7;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd8;
    localparam logic [3:0] ST_TRUNCATED   = 4'd9;

    typedef struct packed {
        logic [7:0] code_low;
        logic [7:0] code_high;
        logic [7:0] type_high;
        logic [7:0] aka_prime_type;
        logic [7:0] identity_type;
        logic [7:0] notification_type;
        logic [7:0] subtype_high;
        logic [7:0] attr_type_high;
    } cfg_t;

    typedef struct packed {
        logic [3:0] byte_role;
        logic [7:0] byte_value;
        logic [7:0] attr_kind;
        logic [9:0] attr_offset;
        logic [3:0] status;
    } result_t;

endpackage

>>> sv/epd_cfg_regs.sv
// ---------------------------------------------------------------------------
// EAP packet decoder configuration registers
// Write-only register file holding code, type and range limits.
// ---------------------------------------------------------------------------
module epd_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [epd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]                    cfg_wdata,
    output epd_pkg::cfg_t                 cfg
);

    epd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_low          <= 8'd1;
            cfg_reg.code_high         <= 8'd6;
            cfg_reg.type_high         <= 8'd255;
            cfg_reg.aka_prime_type    <= 8'd50;
            cfg_reg.identity_type     <= 8'd1;
            cfg_reg.notification_type <= 8'd2;
            cfg_reg.subtype_high      <= 8'd14;
            cfg_reg.attr_type_high    <= 8'd255;
        end else if (cfg_we) begin
            case (cfg_addr)
                epd_pkg::CFG_CODE_LOW:       cfg_reg.code_low          <= cfg_wdata;
                epd_pkg::CFG_CODE_HIGH:      cfg_reg.code_high         <= cfg_wdata;
                epd_pkg::CFG_TYPE_HIGH:      cfg_reg.type_high         <= cfg_wdata;
                epd_pkg::CFG_AKA_PRIME_TYPE: cfg_reg.aka_prime_type    <= cfg_wdata;
                epd_pkg::CFG_IDENTITY_TYPE:  cfg_reg.identity_type     <= cfg_wdata;
                epd_pkg::CFG_NOTIFY_TYPE:    cfg_reg.notification_type <= cfg_wdata;
                epd_pkg::CFG_SUBTYPE_HIGH:   cfg_reg.subtype_high      <= cfg_wdata;
                epd_pkg::CFG_ATTR_TYPE_HIGH: cfg_reg.attr_type_high    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/epd_parse.sv
// ---------------------------------------------------------------------------
// EAP packet decoder parse stage
// Holds the packet state and tags one byte with its role and status.
// ---------------------------------------------------------------------------
module epd_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  epd_pkg::cfg_t     cfg,
    input  logic              item_fire,
    input  logic [7:0]        data_byte,
    input  logic              start_of_pdu,
    input  logic              end_of_input,
    output epd_pkg::result_t  result
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ID      = 4'd1;
    localparam logic [3:0] PH_LENHI   = 4'd2;
    localparam logic [3:0] PH_LENLO   = 4'd3;
    localparam logic [3:0] PH_TYPE    = 4'd4;
    localparam logic [3:0] PH_SUBTYPE = 4'd5;
    localparam logic [3:0] PH_RES1    = 4'd6;
    localparam logic [3:0] PH_RES2    = 4'd7;
    localparam logic [3:0] PH_ATYPE   = 4'd8;
    localparam logic [3:0] PH_ALEN    = 4'd9;
    localparam logic [3:0] PH_AVAL    = 4'd10;
    localparam logic [3:0] PH_RAW     = 4'd11;
    localparam logic [3:0] PH_CODE    = 4'd12;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] bytes_read_reg, bytes_read_next;
    logic [7:0]  attr_type_reg, attr_type_next;
    logic [9:0]  attr_left_reg, attr_left_next;
    logic [9:0]  attr_pos_reg, attr_pos_next;

    logic [3:0]  ph;
    logic [15:0] bytes_read_inc;
    logic [16:0] seen;
    logic        inner_reached;
    logic        inner_over;
    logic [9:0]  attr_left_dec;
    logic [3:0]  role;
    logic [7:0]  kind;
    logic [9:0]  offset;
    logic [3:0]  status;

    // a start flag always opens a new packet
    assign ph = start_of_pdu ? PH_CODE : phase_reg;

    // saturate so an overlong packet always exceeds its length
    assign bytes_read_inc = (bytes_read_reg == 16'hFFFF) ? bytes_read_reg
                                                         : bytes_read_reg + 16'd1;

    always_comb begin
        case (ph)
            PH_CODE, PH_TYPE:                       bytes_read_next = 16'd0;
            PH_SUBTYPE:                             bytes_read_next = 16'd1;
            PH_RES1:                                bytes_read_next = 16'd2;
            PH_RES2:                                bytes_read_next = 16'd3;
            PH_ATYPE, PH_ALEN, PH_AVAL, PH_RAW:     bytes_read_next = bytes_read_inc;
            default:                                bytes_read_next = bytes_read_reg;
        endcase
    end

    // header of five bytes plus the bytes counted after the type byte
    assign seen          = {1'b0, bytes_read_next} + 17'd5;
    assign inner_reached = seen >= {1'b0, total_len_reg};
    assign inner_over    = seen >  {1'b0, total_len_reg};
    assign attr_left_dec = attr_left_reg - 10'd1;

    always_comb begin
        role           = epd_pkg::ROLE_IGNORED;
        kind           = 8'd0;
        offset         = 10'd0;
        status         = epd_pkg::ST_BUSY;
        phase_next     = phase_reg;
        total_len_next = total_len_reg;
        attr_type_next = attr_type_reg;
        attr_left_next = attr_left_reg;
        attr_pos_next  = attr_pos_reg;

        case (ph)
            PH_CODE: begin
                role           = epd_pkg::ROLE_CODE;
                total_len_next = 16'd0;
                attr_type_next = 8'd0;
                attr_left_next = 10'd0;
                attr_pos_next  = 10'd0;
                if (data_byte < cfg.code_low || data_byte > cfg.code_high) begin
                    status = epd_pkg::ST_BAD_CODE;
                end else begin
                    phase_next = PH_ID;
                end
            end
            PH_ID: begin
                role       = epd_pkg::ROLE_ID;
                phase_next = PH_LENHI;
            end
            PH_LENHI: begin
                role           = epd_pkg::ROLE_LEN_HI;
                total_len_next = {data_byte, 8'd0};
                phase_next     = PH_LENLO;
            end
            PH_LENLO: begin
                role           = epd_pkg::ROLE_LEN_LO;
                total_len_next = {total_len_reg[15:8], data_byte};
                if ({total_len_reg[15:8], data_byte} == 16'd4) begin
                    status = epd_pkg::ST_DONE;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                role = epd_pkg::ROLE_TYPE;
                if (data_byte > cfg.type_high) begin
                    status = epd_pkg::ST_BAD_TYPE;
                end else if (data_byte == cfg.aka_prime_type) begin
                    phase_next = PH_SUBTYPE;
                end else if (data_byte == cfg.notification_type ||
                             data_byte == cfg.identity_type) begin
                    if (total_len_reg < 16'd5) begin
                        status = epd_pkg::ST_LEN_MISMATCH;
                    end else if (total_len_reg == 16'd5) begin
                        status = epd_pkg::ST_DONE;
                    end else begin
                        phase_next = PH_RAW;
                    end
                end else begin
                    status = epd_pkg::ST_UNSUPPORTED;
                end
            end
            PH_SUBTYPE: begin
                role = epd_pkg::ROLE_SUBTYPE;
                if (data_byte < 8'd1 || data_byte > cfg.subtype_high) begin
                    status = epd_pkg::ST_BAD_SUBTYPE;
                end else begin
                    phase_next = PH_RES1;
                end
            end
            PH_RES1: begin
                role       = epd_pkg::ROLE_RESERVED;
                phase_next = PH_RES2;
            end
            PH_RES2: begin
                role = epd_pkg::ROLE_RESERVED;
                if (inner_over) begin
                    status = epd_pkg::ST_LEN_MISMATCH;
                end else if (inner_reached) begin
                    status = epd_pkg::ST_DONE;
                end else begin
                    phase_next = PH_ATYPE;
                end
            end
            PH_ATYPE: begin
                role = epd_pkg::ROLE_ATTR_TYPE;
                kind = data_byte;
                if (data_byte < 8'd1 || data_byte > cfg.attr_type_high) begin
                    status = epd_pkg::ST_BAD_ATYPE;
                end else begin
                    attr_type_next = data_byte;
                    phase_next     = PH_ALEN;
                end
            end
            PH_ALEN: begin
                role = epd_pkg::ROLE_ATTR_LEN;
                kind = attr_type_reg;
                if (data_byte < 8'd2) begin
                    status = epd_pkg::ST_BAD_ALEN;
                end else begin
                    // length counts 4-byte words including type and length
                    attr_left_next = {data_byte, 2'b00} - 10'd2;
                    attr_pos_next  = 10'd0;
                    phase_next     = PH_AVAL;
                end
            end
            PH_AVAL: begin
                role           = epd_pkg::ROLE_ATTR_VALUE;
                kind           = attr_type_reg;
                offset         = attr_pos_reg;
                attr_pos_next  = attr_pos_reg + 10'd1;
                attr_left_next = attr_left_dec;
                if (attr_left_dec == 10'd0) begin
                    if (inner_over) begin
                        status = epd_pkg::ST_LEN_MISMATCH;
                    end else if (inner_reached) begin
                        status = epd_pkg::ST_DONE;
                    end else begin
                        phase_next = PH_ATYPE;
                    end
                end
            end
            PH_RAW: begin
                role = epd_pkg::ROLE_RAW;
                if (inner_reached) begin
                    status = epd_pkg::ST_DONE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (role != epd_pkg::ROLE_IGNORED && status == epd_pkg::ST_BUSY && end_of_input) begin
            status = epd_pkg::ST_TRUNCATED;
        end
        // drop to idle on end or error
        if (status != epd_pkg::ST_BUSY) begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            total_len_reg  <= 16'd0;
            bytes_read_reg <= 16'd0;
            attr_type_reg  <= 8'd0;
            attr_left_reg  <= 10'd0;
            attr_pos_reg   <= 10'd0;
        end else if (item_fire) begin
            phase_reg      <= phase_next;
            total_len_reg  <= total_len_next;
            bytes_read_reg <= bytes_read_next;
            attr_type_reg  <= attr_type_next;
            attr_left_reg  <= attr_left_next;
            attr_pos_reg   <= attr_pos_next;
        end
    end

    assign result.byte_role   = role;
    assign result.byte_value  = data_byte;
    assign result.attr_kind   = kind;
    assign result.attr_offset = offset;
    assign result.status      = status;

endmodule

>>> sv/eap_pdu_decoder.sv
// ---------------------------------------------------------------------------
// EAP packet decoder
// Tags each byte of an EAP / AKA' packet stream with its role and status.
// ---------------------------------------------------------------------------
// The decoder takes one byte per cycle and returns exactly one tagged item per
// byte, in order. Throughput is one item every cycle with both sides ready;
// the input register and the result register bracket the single parse stage.
// A byte with s_tuser high starts a new packet; s_tlast marks the last byte
// the source holds for it. m_tlast is high when a byte ends the packet or
// raises an error, after which bytes are tagged as ignored until the next
// start. Registers may be written only while idle.
module eap_pdu_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // fields: data_byte[7:0]
    input  logic [7:0]                    s_tdata,
    // fields: start_of_pdu[0]
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // fields: byte_value[7:0], attr_kind[15:8], attr_offset[25:16],
    //         status[29:26], zero fill[31:30]
    output logic [31:0]                   m_tdata,
    // fields: byte_role[3:0]
    output logic [3:0]                    m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [epd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]                    cfg_wdata
);

    epd_pkg::cfg_t    cfg;
    epd_pkg::result_t result;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_sop_reg;
    logic       in_eoi_reg;
    logic       out_valid_reg;
    epd_pkg::result_t out_result_reg;
    logic       advance;
    logic       item_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign item_fire = in_valid_reg && advance;

    epd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    epd_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item_fire    (item_fire),
        .data_byte    (in_data_reg),
        .start_of_pdu (in_sop_reg),
        .end_of_input (in_eoi_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_sop_reg  <= s_tuser;
            in_eoi_reg  <= s_tlast;
        end
        if (item_fire) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.byte_role;
    assign m_tlast  = out_result_reg.status != epd_pkg::ST_BUSY;
    assign m_tdata  = {2'b00, out_result_reg.status, out_result_reg.attr_offset,
                       out_result_reg.attr_kind, out_result_reg.byte_value};

    // an ignored byte never ends a packet and belongs to no attribute
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == epd_pkg::ROLE_IGNORED) |->
            (!m_tlast && m_tdata[15:8] == 8'd0))
        else $error("ignored item carries status or attribute kind");

    // only attribute value bytes carry an offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[25:16] != 10'd0) |-> (m_tuser == epd_pkg::ROLE_ATTR_VALUE))
        else $error("attribute offset on a non-value item");

    // a held input item is not lost while the result stage stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register dropped a stalled item");

    // the result register takes a new item only when it moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_result_reg)))
        else $error("result register changed while stalled");

endmodule
